### hdl/rgb_to_hsi_pixel_top_defines.svh
// Assertion macros for the RGB to HSI pixel converter
`ifndef RGB_TO_HSI_PIXEL_TOP_DEFINES_SVH
`define RGB_TO_HSI_PIXEL_TOP_DEFINES_SVH

// Clocked implication check, disabled during reset
`define R2H_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Stall check: while cond holds, sig is held on the next edge
`define R2H_HOLD(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

### hdl/rgb2hsi_pkg.sv
// Package: types, widths and angle table for the RGB to HSI converter
`timescale 1ns / 1ps
package rgb2hsi_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int VEC_W = 30;
	localparam int SQRT3_Q16 = 113512;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam int QUO_W = 8;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
		32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
		32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
	};

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic [31:0]             z;
		logic                    byp;     // angle settled before rotation
		logic [17:0]             rem;     // saturation dividend remainder
		logic [9:0]              div;     // component sum (1 for black)
		logic [QUO_W-1:0]        quo;
		logic [7:0]              inten;
	} pipe_t;

endpackage

### hdl/rgb2hsi_ifs.sv
// Channel interfaces: RGB pixel request and HSI result request
`timescale 1ns / 1ps
interface rgb2hsi_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rgb2hsi_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue_out;
	logic [7:0] saturation_out;
	logic [7:0] intensity_out;
	modport source (output valid, hue_out, saturation_out, intensity_out, input ready);
	modport sink (input valid, hue_out, saturation_out, intensity_out, output ready);
endinterface

### hdl/rgb2hsi_prep.sv
// First stage: sum, minimum, intensity, CORDIC start vector
`timescale 1ns / 1ps
module rgb2hsi_prep import rgb2hsi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       v_in,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       v_s1,
	output pipe_t      d_s1
);
	logic [9:0]              sum;
	logic [7:0]              mn;
	logic [9:0]              diff;
	logic [19:0]             inten_prod;
	logic signed [10:0]      xr;
	logic signed [8:0]       gb;
	logic signed [VEC_W-1:0] x0;
	logic signed [VEC_W-1:0] y0;
	pipe_t                   nxt;

	always_comb begin
		sum = 10'(red) + 10'(green) + 10'(blue);
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		diff = sum - 10'(3 * 10'(mn));
		inten_prod = 20'(sum) * 20'd683;   // floor(sum/3) for sum <= 765
		xr = 11'(2 * 11'(red)) - 11'(green) - 11'(blue);
		gb = 9'(green) - 9'(blue);
		x0 = VEC_W'(xr) <<< 16;
		y0 = VEC_W'(gb) * VEC_W'(SQRT3_Q16);
		nxt.rem = {diff, 8'b0} - 18'(diff);
		nxt.div = (sum == '0) ? 10'd1 : sum;
		nxt.quo = '0;
		nxt.inten = inten_prod[18:11];
		nxt.byp = (y0 == '0);
		if (y0 == '0) begin
			nxt.x = x0;
			nxt.y = y0;
			nxt.z = x0[VEC_W-1] ? HALF_TURN : '0;
		end else if (x0[VEC_W-1]) begin
			nxt.x = -x0;
			nxt.y = -y0;
			nxt.z = HALF_TURN;
		end else begin
			nxt.x = x0;
			nxt.y = y0;
			nxt.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end
endmodule

### hdl/rgb2hsi_cstage.sv
// Pipeline stage: two CORDIC vectoring steps and, in the first QUO_W stages, one divider bit
`timescale 1ns / 1ps
module rgb2hsi_cstage import rgb2hsi_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  v_in,
	input  pipe_t d_in,
	output logic  v_q,
	output pipe_t d_q
);
	localparam int FIRST = STAGE * STEPS_PER_STAGE;
	// quotient bit settled here; stages past the last bit do no division
	localparam int QBIT = (STAGE < QUO_W) ? (QUO_W - 1 - STAGE) : 0;

	pipe_t                   nxt;
	logic signed [VEC_W-1:0] dx;
	logic signed [VEC_W-1:0] dy;
	logic [17:0]             sh;

	always_comb begin
		nxt = d_in;
		dx = '0;
		dy = '0;
		sh = '0;
		for (int k = 0; k < STEPS_PER_STAGE; k++) begin
			dx = nxt.y >>> (FIRST + k);
			dy = nxt.x >>> (FIRST + k);
			if (!nxt.byp) begin
				if (!nxt.y[VEC_W-1]) begin
					nxt.x = nxt.x + dx;
					nxt.y = nxt.y - dy;
					nxt.z = nxt.z + ATAN_TAB[FIRST + k];
				end else begin
					nxt.x = nxt.x - dx;
					nxt.y = nxt.y + dy;
					nxt.z = nxt.z - ATAN_TAB[FIRST + k];
				end
			end
		end
		// restoring division, one quotient bit, MSB first
		if (STAGE < QUO_W) begin
			sh = 18'(d_in.div) << QBIT;
			if (d_in.rem >= sh) begin
				nxt.rem = d_in.rem - sh;
				nxt.quo[QBIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end
endmodule

### hdl/rgb2hsi_post.sv
// Output stage: angle to 8-bit hue, result register
`timescale 1ns / 1ps
module rgb2hsi_post import rgb2hsi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       v_in,
	input  pipe_t      d_in,
	output logic       v_q,
	output logic [7:0] hue_q,
	output logic [7:0] sat_q,
	output logic [7:0] inten_q
);
	logic [39:0] prod;

	// angle * 255 as (angle << 8) - angle
	assign prod = {d_in.z, 8'b0} - {8'b0, d_in.z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= prod[39:32];
			sat_q <= d_in.quo;
			inten_q <= d_in.inten;
		end
	end
endmodule

### hdl/rgb_to_hsi_pixel_top.sv
// Top level: pipelined RGB to HSI pixel converter
//
//  channel  | role   | payload
//  ---------+--------+---------------------------------------------
//  pixel    | sink   | red_in, green_in, blue_in      (8 bits each)
//  result   | source | hue_out, saturation_out, intensity_out
//
// One pixel per clock while the result is not stalled; prep stage, ten CORDIC
// stages of two steps each, output stage. The CORDIC chain sets the depth.
// arst_n clears only the stage valid bits; payload registers are not reset.
// A stalled result freezes the whole pipeline together; nothing is dropped
// or repeated. While frozen no pixel enters, even if the pipe holds bubbles.
`timescale 1ns / 1ps
`include "rgb_to_hsi_pixel_top_defines.svh"
module rgb_to_hsi_pixel_top import rgb2hsi_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	rgb2hsi_pix_if.sink  pixel,
	rgb2hsi_res_if.source result
);
	localparam int NSTG = CORDIC_STAGES + 1;

	logic  en;
	logic  v   [NSTG];
	pipe_t d   [NSTG];
	logic  v_out;

	// global advance: move when the result slot is free or being taken
	assign en = !v_out || result.ready;
	assign pixel.ready = en;

	rgb2hsi_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (pixel.valid),
		.red    (pixel.red_in),
		.green  (pixel.green_in),
		.blue   (pixel.blue_in),
		.v_s1   (v[0]),
		.d_s1   (d[0])
	);

	for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
		rgb2hsi_cstage #(.STAGE(s)) u_cstage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (v[s]),
			.d_in   (d[s]),
			.v_q    (v[s+1]),
			.d_q    (d[s+1])
		);
	end

	rgb2hsi_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v[NSTG-1]),
		.d_in    (d[NSTG-1]),
		.v_q     (v_out),
		.hue_q   (result.hue_out),
		.sat_q   (result.saturation_out),
		.inten_q (result.intensity_out)
	);

	assign result.valid = v_out;

	// accepted request shows up in the first stage
	`R2H_ASSERT(a_enter, pixel.valid && pixel.ready |=> v[0], "accepted pixel lost at entry")
	// a blocked result freezes the middle stage valid and the hue output
	`R2H_HOLD(a_freeze_mid, v_out && !result.ready, v[CORDIC_STAGES/2], "pipe moved during stall")
	`R2H_HOLD(a_freeze_hue, v_out && !result.ready, result.hue_out, "hue changed during stall")
	// a blocked result is still offered next cycle
	`R2H_ASSERT(a_keep, v_out && !result.ready |=> v_out, "result dropped while stalled")
endmodule
